### design/qor_pkg.sv
// Shared types, widths, codes and arithmetic helpers of the quaternion rotator.
`default_nettype none

package qor_pkg;

    // Field widths
    localparam int QW      = 16;            // quaternion component, Q2.14
    localparam int VW      = 24;            // vector component, Q8.16
    localparam int CFG_W   = 16;            // widest configuration register
    localparam int THR_W   = 15;            // renormalize threshold
    localparam int IDX_W   = 2;             // configuration index

    // Shared multiply-accumulate unit
    localparam int MAC_AW  = 25;
    localparam int MAC_BW  = 17;
    localparam int PROD_W  = MAC_AW + MAC_BW;
    localparam int ACC_W   = 60;
    localparam int SW      = ACC_W + 1;     // signed quotient width
    localparam int HI_SH   = 21;            // split point of wide operands

    // Intermediate widths
    localparam int TW      = 42;            // first product of the rotation
    localparam int LEN2_W  = 33;            // squared length
    localparam int THR2_W  = 2 * THR_W;     // squared threshold
    localparam int ROOT_W  = THR_W;         // length from the square root
    localparam int GRP_W   = 4;
    localparam int STEP_W  = 4;

    // Divider widths
    localparam int DIV_NW  = ACC_W;
    localparam int DIV_DW  = LEN2_W;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_STEP_COS = 2'd0;
    localparam logic [IDX_W-1:0] REG_STEP_SIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_THRESH   = 2'd2;

    // Item kinds
    localparam logic KIND_TURN   = 1'b0;
    localparam logic KIND_ROTATE = 1'b1;

    // Last accumulation group of each kind
    localparam logic [GRP_W-1:0] TURN_LAST_GRP = 4'd8;
    localparam logic [GRP_W-1:0] ROT_LAST_GRP  = 4'd7;

    // Reset values
    localparam logic signed [QW-1:0] STEP_COS_RST = 16'sd16135;
    localparam logic signed [QW-1:0] STEP_SIN_RST = 16'sd2845;
    localparam logic [THR_W-1:0]     THRESH_RST   = 15'd16384;
    localparam logic signed [QW-1:0] Q_ONE        = 16'sd16384;

    typedef struct packed {
        logic                   kind;
        logic                   turn_sign;
        logic signed [VW-1:0]   vec_x;
        logic signed [VW-1:0]   vec_y;
        logic signed [VW-1:0]   vec_z;
    } in_item_t;

    typedef struct packed {
        logic signed [QW-1:0]   out_s;
        logic signed [VW-1:0]   out_x;
        logic signed [VW-1:0]   out_y;
        logic signed [VW-1:0]   out_z;
    } out_item_t;

    // One operation for the shared multiply-accumulate unit
    typedef struct packed {
        logic                     valid;
        logic                     clr;
        logic                     neg;
        logic                     hi;
        logic signed [MAC_AW-1:0] a;
        logic signed [MAC_BW-1:0] b;
    } mac_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    // Number of products accumulated in each group
    function automatic logic [STEP_W-1:0] group_ops(input logic kind,
                                                    input logic [GRP_W-1:0] grp);
        logic [STEP_W-1:0] n;
        n = 4'd1;
        if (kind == KIND_TURN)
        begin
            if (grp >= 4'd3 && grp <= 4'd7)
                n = 4'd4;
        end
        else
        begin
            if (grp == 4'd0)
                n = 4'd4;
            else if (grp <= 4'd4)
                n = 4'd3;
            else
                n = 4'd8;
        end
        return n;
    endfunction

    // Divide by 2^k, rounding to nearest with ties away from zero
    function automatic logic signed [ACC_W-1:0] round_shift(input logic signed [ACC_W-1:0] v,
                                                            input int unsigned k);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        r   = (mag + (ACC_W'(1) << (k - 1))) >> k;
        return v[ACC_W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic ovf16(input logic signed [SW-1:0] v);
        return (v > SW'(32767)) || (v < -SW'(32768));
    endfunction

    function automatic logic signed [QW-1:0] sat16(input logic signed [SW-1:0] v);
        logic signed [QW-1:0] r;
        if (v > SW'(32767))
            r = 16'sh7FFF;
        else if (v < -SW'(32768))
            r = -16'sh8000;
        else
            r = QW'(v);
        return r;
    endfunction

    function automatic logic signed [VW-1:0] sat24(input logic signed [SW-1:0] v);
        logic signed [VW-1:0] r;
        if (v > SW'(8388607))
            r = 24'sh7FFFFF;
        else if (v < -SW'(8388608))
            r = -24'sh800000;
        else
            r = VW'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

### design/qor_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate.
`default_nettype none

module qor_mac
    import qor_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mac_op_t                 op,
    output logic signed [ACC_W-1:0]      acc
);

    logic                      pv_reg, pv_next;
    logic                      pclr_reg, pneg_reg, phi_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   term;

    // Align the registered product
    always_comb
    begin
        term = phi_reg ? (ACC_W'(prod_reg) <<< HI_SH) : ACC_W'(prod_reg);
        pv_next = op.valid;
        acc_next = acc_reg;
        if (pv_reg)
        begin
            if (pclr_reg)
                acc_next = pneg_reg ? -term : term;
            else
                acc_next = pneg_reg ? acc_reg - term : acc_reg + term;
        end
    end

    // Hold the valid flag of the product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= pv_next;
    end

    // Multiply and accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= op.a * op.b;
        pclr_reg <= op.clr;
        pneg_reg <= op.neg;
        phi_reg  <= op.hi;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

### design/qor_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module qor_div
    import qor_pkg::*;
#(
    parameter int NUM_W = DIV_NW,
    parameter int DEN_W = DIV_DW
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    output logic                   done,
    output logic [NUM_W-1:0]       quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W:0]     trial;
    logic               ge;

    // Shift in one dividend bit and try a subtract
    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            num_next = {num_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

`default_nettype wire

### design/qor_root.sv
// Integer square root, one result bit per cycle.
`default_nettype none

module qor_root
    import qor_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [THR2_W-1:0]  val,
    output logic                    done,
    output logic [ROOT_W-1:0]       root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int SH_W  = REM_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [THR2_W-1:0]  val_reg, val_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [SH_W-1:0]    rem_sh;
    logic [SH_W-1:0]    trial;

    // Bring down two bits and test the next root bit
    always_comb
    begin
        rem_sh    = {rem_reg, val_reg[THR2_W-1 -: 2]};
        trial     = SH_W'({root_reg, 2'b01});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ROOT_W);
            val_next  = val;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[THR2_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### design/quaternion_orientation_rotator_top.sv
// Quaternion orientation rotator: sequencer around a shared multiply-accumulate unit.
//
// Keeps an orientation quaternion (Q2.14). A beat of kind 0 on the input channel
// turns it by the configured step about the given axis; a beat of kind 1 rotates
// the given vector (Q8.16) by it. Each input beat gives one output beat.
// Input and output channels use valid/ready; the write port (wr_en, wr_index,
// wr_data) sets step_cos, step_sin and renorm_threshold. The user must write them
// only while the block is idle; the block itself does not enforce it.
// One item is in work at a time; in_ready is high only while no item is at work.
// Timing is set by the shared multiplier (one product a cycle, then a drain per
// accumulated sum) and the one-bit-per-cycle divider and root units. A turn that
// renormalizes adds a square root and four divisions; a rotate adds three
// divisions, skipped with a zero orientation.
// in_ready returns in the same cycle that the result enters the output register.
// A finished result waits in the output register; the next item is taken while it
// waits, and its own result is held until the receiver takes the earlier one.
// Reset returns the orientation to identity and the registers to their defaults.
`default_nettype none

module quaternion_orientation_rotator_top
    import qor_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire in_item_t            in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output out_item_t                out_data,
    input  wire logic                wr_en,
    input  wire logic [IDX_W-1:0]    wr_index,
    input  wire logic [CFG_W-1:0]    wr_data
);

    // Control and configuration
    state_t                  state_reg, state_next;
    logic [GRP_W-1:0]        grp_reg, grp_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [1:0]              didx_reg, didx_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [QW-1:0]    cos_reg, cos_next;
    logic signed [QW-1:0]    sin_reg, sin_next;
    logic [THR_W-1:0]        thr_reg, thr_next;
    logic signed [QW-1:0]    orient_reg [4];
    logic signed [QW-1:0]    orient_next [4];

    // Item payload
    logic                    kind_reg, kind_next;
    logic                    sign_reg, sign_next;
    logic signed [VW-1:0]    w_reg [3];
    logic signed [VW-1:0]    w_next [3];
    logic signed [MAC_AW-1:0] a_reg [3];
    logic signed [MAC_AW-1:0] a_next [3];
    logic signed [QW-1:0]    n16_reg [4];
    logic signed [QW-1:0]    n16_next [4];
    logic                    big_reg, big_next;
    logic [LEN2_W-1:0]       len2_reg, len2_next;
    logic [LEN2_W-1:0]       l2_reg, l2_next;
    logic [ROOT_W-1:0]       len_reg, len_next;
    logic signed [TW-1:0]    t_reg [4];
    logic signed [TW-1:0]    t_next [4];
    logic signed [ACC_W-1:0] rn_reg [3];
    logic signed [ACC_W-1:0] rn_next [3];
    logic signed [VW-1:0]    rv_reg [3];
    logic signed [VW-1:0]    rv_next [3];
    out_item_t               out_reg, out_next;

    // Unit connections
    mac_op_t                 mac_op;
    logic signed [ACC_W-1:0] acc;
    logic                    div_start, div_done;
    logic [DIV_NW-1:0]       div_num, div_quo;
    logic [DIV_DW-1:0]       div_den;
    logic                    div_neg;
    logic                    root_start, root_done;
    logic [ROOT_W-1:0]       root_q;

    // Sequencer helpers
    logic [STEP_W-1:0]       nops;
    logic [GRP_W-1:0]        last_grp;
    logic signed [MAC_BW-1:0] sn;
    logic signed [MAC_BW-1:0] cb;
    logic signed [MAC_BW-1:0] qb [4];
    logic signed [MAC_AW-1:0] qa [4];
    logic signed [MAC_AW-1:0] wa [3];
    logic signed [ACC_W-1:0] rs16, rs14;
    logic signed [SW-1:0]    q_s;
    logic signed [QW-1:0]    n_sel;
    logic signed [ACC_W-1:0] rn_sel;
    logic [QW:0]             n_mag;
    logic [ACC_W-1:0]        rn_mag;
    logic                    renorm;
    logic [1:0]              term;

    qor_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .acc   (acc)
    );

    qor_div #(.NUM_W(DIV_NW), .DEN_W(DIV_DW)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    qor_root u_root
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .val   (len2_reg[THR2_W-1:0]),
        .done  (root_done),
        .root  (root_q)
    );

    // Widen operands for the multiplier
    always_comb
    begin
        sn = sign_reg ? -MAC_BW'(sin_reg) : MAC_BW'(sin_reg);
        cb = MAC_BW'(cos_reg);
        for (int i = 0; i < 4; i++)
        begin
            qb[i] = MAC_BW'(orient_reg[i]);
            qa[i] = MAC_AW'(orient_reg[i]);
        end
        for (int i = 0; i < 3; i++)
            wa[i] = MAC_AW'(w_reg[i]);
        nops     = group_ops(kind_reg, grp_reg);
        last_grp = (kind_reg == KIND_TURN) ? TURN_LAST_GRP : ROT_LAST_GRP;
        term     = step_reg[2:1];
    end

    // Low or high half of a first-stage rotation product
    function automatic logic signed [MAC_AW-1:0] t_half(input logic signed [TW-1:0] t,
                                                        input logic hi);
        return hi ? MAC_AW'($signed(t[TW-1:HI_SH])) : MAC_AW'({1'b0, t[HI_SH-1:0]});
    endfunction

    // Pick the product for the current group and step
    always_comb
    begin
        mac_op = '0;
        if (state_reg == ST_MAC && step_reg < nops)
        begin
            mac_op.valid = 1'b1;
            mac_op.clr   = (step_reg == '0);
            if (kind_reg == KIND_TURN)
            begin
                unique case (grp_reg)
                    4'd0, 4'd1, 4'd2:
                    begin
                        unique case (grp_reg)
                            4'd0:    mac_op.a = wa[0];
                            4'd1:    mac_op.a = wa[1];
                            default: mac_op.a = wa[2];
                        endcase
                        mac_op.b = sn;
                    end
                    4'd3:
                    begin
                        unique case (step_reg[1:0])
                            2'd0: begin mac_op.a = qa[0];   mac_op.b = cb;    end
                            2'd1: begin mac_op.a = a_reg[0]; mac_op.b = qb[1]; mac_op.neg = 1'b1; end
                            2'd2: begin mac_op.a = a_reg[1]; mac_op.b = qb[2]; mac_op.neg = 1'b1; end
                            default: begin mac_op.a = a_reg[2]; mac_op.b = qb[3]; mac_op.neg = 1'b1; end
                        endcase
                    end
                    4'd4:
                    begin
                        unique case (step_reg[1:0])
                            2'd0: begin mac_op.a = a_reg[0]; mac_op.b = qb[0]; end
                            2'd1: begin mac_op.a = qa[1];    mac_op.b = cb;    end
                            2'd2: begin mac_op.a = a_reg[2]; mac_op.b = qb[2]; end
                            default: begin mac_op.a = a_reg[1]; mac_op.b = qb[3]; mac_op.neg = 1'b1; end
                        endcase
                    end
                    4'd5:
                    begin
                        unique case (step_reg[1:0])
                            2'd0: begin mac_op.a = a_reg[1]; mac_op.b = qb[0]; end
                            2'd1: begin mac_op.a = qa[2];    mac_op.b = cb;    end
                            2'd2: begin mac_op.a = a_reg[0]; mac_op.b = qb[3]; end
                            default: begin mac_op.a = a_reg[2]; mac_op.b = qb[1]; mac_op.neg = 1'b1; end
                        endcase
                    end
                    4'd6:
                    begin
                        unique case (step_reg[1:0])
                            2'd0: begin mac_op.a = a_reg[2]; mac_op.b = qb[0]; end
                            2'd1: begin mac_op.a = qa[3];    mac_op.b = cb;    end
                            2'd2: begin mac_op.a = a_reg[1]; mac_op.b = qb[1]; end
                            default: begin mac_op.a = a_reg[0]; mac_op.b = qb[2]; mac_op.neg = 1'b1; end
                        endcase
                    end
                    4'd7:
                    begin
                        unique case (step_reg[1:0])
                            2'd0: begin mac_op.a = MAC_AW'(n16_reg[0]); mac_op.b = MAC_BW'(n16_reg[0]); end
                            2'd1: begin mac_op.a = MAC_AW'(n16_reg[1]); mac_op.b = MAC_BW'(n16_reg[1]); end
                            2'd2: begin mac_op.a = MAC_AW'(n16_reg[2]); mac_op.b = MAC_BW'(n16_reg[2]); end
                            default: begin mac_op.a = MAC_AW'(n16_reg[3]); mac_op.b = MAC_BW'(n16_reg[3]); end
                        endcase
                    end
                    default:
                    begin
                        mac_op.a = MAC_AW'(thr_reg);
                        mac_op.b = MAC_BW'(thr_reg);
                    end
                endcase
            end
            else
            begin
                unique case (grp_reg)
                    4'd0:
                    begin
                        unique case (step_reg[1:0])
                            2'd0: begin mac_op.a = qa[0]; mac_op.b = qb[0]; end
                            2'd1: begin mac_op.a = qa[1]; mac_op.b = qb[1]; end
                            2'd2: begin mac_op.a = qa[2]; mac_op.b = qb[2]; end
                            default: begin mac_op.a = qa[3]; mac_op.b = qb[3]; end
                        endcase
                    end
                    4'd1:
                    begin
                        mac_op.neg = 1'b1;
                        unique case (step_reg[1:0])
                            2'd0: begin mac_op.a = wa[0]; mac_op.b = qb[1]; end
                            2'd1: begin mac_op.a = wa[1]; mac_op.b = qb[2]; end
                            default: begin mac_op.a = wa[2]; mac_op.b = qb[3]; end
                        endcase
                    end
                    4'd2:
                    begin
                        unique case (step_reg[1:0])
                            2'd0: begin mac_op.a = wa[0]; mac_op.b = qb[0]; end
                            2'd1: begin mac_op.a = wa[2]; mac_op.b = qb[2]; end
                            default: begin mac_op.a = wa[1]; mac_op.b = qb[3]; mac_op.neg = 1'b1; end
                        endcase
                    end
                    4'd3:
                    begin
                        unique case (step_reg[1:0])
                            2'd0: begin mac_op.a = wa[1]; mac_op.b = qb[0]; end
                            2'd1: begin mac_op.a = wa[0]; mac_op.b = qb[3]; end
                            default: begin mac_op.a = wa[2]; mac_op.b = qb[1]; mac_op.neg = 1'b1; end
                        endcase
                    end
                    4'd4:
                    begin
                        unique case (step_reg[1:0])
                            2'd0: begin mac_op.a = wa[2]; mac_op.b = qb[0]; end
                            2'd1: begin mac_op.a = wa[1]; mac_op.b = qb[1]; end
                            default: begin mac_op.a = wa[0]; mac_op.b = qb[2]; mac_op.neg = 1'b1; end
                        endcase
                    end
                    4'd5:
                    begin
                        mac_op.hi = step_reg[0];
                        unique case (term)
                            2'd0: begin mac_op.a = t_half(t_reg[1], step_reg[0]); mac_op.b = qb[0]; end
                            2'd1: begin mac_op.a = t_half(t_reg[0], step_reg[0]); mac_op.b = qb[1]; mac_op.neg = 1'b1; end
                            2'd2: begin mac_op.a = t_half(t_reg[2], step_reg[0]); mac_op.b = qb[3]; mac_op.neg = 1'b1; end
                            default: begin mac_op.a = t_half(t_reg[3], step_reg[0]); mac_op.b = qb[2]; end
                        endcase
                    end
                    4'd6:
                    begin
                        mac_op.hi = step_reg[0];
                        unique case (term)
                            2'd0: begin mac_op.a = t_half(t_reg[2], step_reg[0]); mac_op.b = qb[0]; end
                            2'd1: begin mac_op.a = t_half(t_reg[0], step_reg[0]); mac_op.b = qb[2]; mac_op.neg = 1'b1; end
                            2'd2: begin mac_op.a = t_half(t_reg[3], step_reg[0]); mac_op.b = qb[1]; mac_op.neg = 1'b1; end
                            default: begin mac_op.a = t_half(t_reg[1], step_reg[0]); mac_op.b = qb[3]; end
                        endcase
                    end
                    default:
                    begin
                        mac_op.hi = step_reg[0];
                        unique case (term)
                            2'd0: begin mac_op.a = t_half(t_reg[3], step_reg[0]); mac_op.b = qb[0]; end
                            2'd1: begin mac_op.a = t_half(t_reg[0], step_reg[0]); mac_op.b = qb[3]; mac_op.neg = 1'b1; end
                            2'd2: begin mac_op.a = t_half(t_reg[1], step_reg[0]); mac_op.b = qb[2]; mac_op.neg = 1'b1; end
                            default: begin mac_op.a = t_half(t_reg[2], step_reg[0]); mac_op.b = qb[1]; end
                        endcase
                    end
                endcase
            end
        end
    end

    // Build the dividend and divisor of the current division
    always_comb
    begin
        unique case (didx_reg)
            2'd0:    begin n_sel = n16_reg[0]; rn_sel = rn_reg[0]; end
            2'd1:    begin n_sel = n16_reg[1]; rn_sel = rn_reg[1]; end
            2'd2:    begin n_sel = n16_reg[2]; rn_sel = rn_reg[2]; end
            default: begin n_sel = n16_reg[3]; rn_sel = '0;        end
        endcase
        n_mag  = n_sel[QW-1] ? (QW+1)'(-(QW+1)'(n_sel)) : (QW+1)'(n_sel);
        rn_mag = rn_sel[ACC_W-1] ? ACC_W'(-rn_sel) : ACC_W'(rn_sel);
        if (kind_reg == KIND_TURN)
        begin
            div_neg = n_sel[QW-1];
            div_num = DIV_NW'({n_mag, 14'd0}) + DIV_NW'(len_reg >> 1);
            div_den = DIV_DW'(len_reg);
        end
        else
        begin
            div_neg = rn_sel[ACC_W-1];
            div_num = DIV_NW'(rn_mag) + DIV_NW'(l2_reg >> 1);
            div_den = l2_reg;
        end
        q_s  = div_neg ? -$signed(SW'(div_quo)) : $signed(SW'(div_quo));
        rs16 = round_shift(acc, 16);
        rs14 = round_shift(acc, 14);
    end

    // Next state and datapath register updates
    always_comb
    begin
        state_next     = state_reg;
        grp_next       = grp_reg;
        step_next      = step_reg;
        didx_next      = didx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cos_next       = cos_reg;
        sin_next       = sin_reg;
        thr_next       = thr_reg;
        orient_next    = orient_reg;
        kind_next      = kind_reg;
        sign_next      = sign_reg;
        w_next         = w_reg;
        a_next         = a_reg;
        n16_next       = n16_reg;
        big_next       = big_reg;
        len2_next      = len2_reg;
        l2_next        = l2_reg;
        len_next       = len_reg;
        t_next         = t_reg;
        rn_next        = rn_reg;
        rv_next        = rv_reg;
        out_next       = out_reg;
        div_start      = 1'b0;
        root_start     = 1'b0;
        renorm         = !big_reg && (len2_reg != '0) &&
                         (len2_reg < LEN2_W'(acc[THR2_W-1:0]));

        // Take configuration writes
        if (wr_en)
        begin
            unique case (wr_index)
                REG_STEP_COS: cos_next = wr_data;
                REG_STEP_SIN: sin_next = wr_data;
                REG_THRESH:   thr_next = wr_data[THR_W-1:0];
                default:      ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = in_data.kind;
                    sign_next  = in_data.turn_sign;
                    w_next[0]  = in_data.vec_x;
                    w_next[1]  = in_data.vec_y;
                    w_next[2]  = in_data.vec_z;
                    grp_next   = '0;
                    step_next  = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (step_reg == nops + 1'b1)
                begin
                    // Store the finished sum
                    step_next = '0;
                    grp_next  = grp_reg + 1'b1;
                    if (kind_reg == KIND_TURN)
                    begin
                        if (grp_reg < 4'd3)
                            a_next[grp_reg[1:0]] = MAC_AW'(rs16);
                        else if (grp_reg < 4'd7)
                        begin
                            n16_next[2'(grp_reg - 4'd3)] = sat16(SW'(rs14));
                            big_next = ovf16(SW'(rs14)) || (big_reg && grp_reg != 4'd3);
                        end
                        else if (grp_reg == 4'd7)
                            len2_next = acc[LEN2_W-1:0];
                    end
                    else
                    begin
                        if (grp_reg == 4'd0)
                            l2_next = acc[LEN2_W-1:0];
                        else if (grp_reg < 4'd5)
                            t_next[2'(grp_reg - 4'd1)] = acc[TW-1:0];
                        else
                        begin
                            unique case (grp_reg)
                                4'd5:    rn_next[0] = acc;
                                4'd6:    rn_next[1] = acc;
                                default: rn_next[2] = acc;
                            endcase
                        end
                    end
                    if (grp_reg == last_grp)
                    begin
                        didx_next = '0;
                        if (kind_reg == KIND_TURN)
                            state_next = renorm ? ST_ROOT_GO : ST_DONE;
                        else if (l2_reg == '0)
                        begin
                            rv_next[0] = '0;
                            rv_next[1] = '0;
                            rv_next[2] = '0;
                            state_next = ST_DONE;
                        end
                        else
                            state_next = ST_DIV_GO;
                    end
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_ROOT_GO:
            begin
                root_start = 1'b1;
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    len_next   = root_q;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (kind_reg == KIND_TURN)
                        n16_next[didx_reg] = sat16(q_s);
                    else
                    begin
                        unique case (didx_reg)
                            2'd0:    rv_next[0] = sat24(q_s);
                            2'd1:    rv_next[1] = sat24(q_s);
                            default: rv_next[2] = sat24(q_s);
                        endcase
                    end
                    didx_next = didx_reg + 1'b1;
                    if ((kind_reg == KIND_TURN && didx_reg == 2'd3) ||
                        (kind_reg == KIND_ROTATE && didx_reg == 2'd2))
                        state_next = ST_DONE;
                    else
                        state_next = ST_DIV_GO;
                end
            end
            ST_DONE:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    if (kind_reg == KIND_TURN)
                    begin
                        out_next.out_s = n16_reg[0];
                        out_next.out_x = VW'(n16_reg[1]);
                        out_next.out_y = VW'(n16_reg[2]);
                        out_next.out_z = VW'(n16_reg[3]);
                        orient_next    = n16_reg;
                    end
                    else
                    begin
                        out_next.out_s = '0;
                        out_next.out_x = rv_reg[0];
                        out_next.out_y = rv_reg[1];
                        out_next.out_z = rv_reg[2];
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control, configuration and orientation registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            grp_reg       <= '0;
            step_reg      <= '0;
            didx_reg      <= '0;
            out_valid_reg <= 1'b0;
            cos_reg       <= STEP_COS_RST;
            sin_reg       <= STEP_SIN_RST;
            thr_reg       <= THRESH_RST;
            orient_reg[0] <= Q_ONE;
            orient_reg[1] <= '0;
            orient_reg[2] <= '0;
            orient_reg[3] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            grp_reg       <= grp_next;
            step_reg      <= step_next;
            didx_reg      <= didx_next;
            out_valid_reg <= out_valid_next;
            cos_reg       <= cos_next;
            sin_reg       <= sin_next;
            thr_reg       <= thr_next;
            orient_reg    <= orient_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        sign_reg <= sign_next;
        w_reg    <= w_next;
        a_reg    <= a_next;
        n16_reg  <= n16_next;
        big_reg  <= big_next;
        len2_reg <= len2_next;
        l2_reg   <= l2_next;
        len_reg  <= len_next;
        t_reg    <= t_next;
        rn_reg   <= rn_next;
        rv_reg   <= rv_next;
        out_reg  <= out_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Sequencer never runs past the last group of its kind
    a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (grp_reg <= last_grp))
        else $error("accumulation group out of range");

    // Divisions only start with a nonzero divisor
    a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (div_den != '0))
        else $error("division started with zero divisor");

    // Square root only runs for a turn whose product is in range
    a_root_turn: assert property (@(posedge clk) disable iff (!rst_n)
        root_start |-> (kind_reg == KIND_TURN && !big_reg))
        else $error("square root started outside a renormalizing turn");

    // Orientation changes only when a turn result is delivered
    a_orient_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ST_DONE && kind_reg == KIND_TURN) |=>
            ($stable(orient_reg[0]) && $stable(orient_reg[1]) &&
             $stable(orient_reg[2]) && $stable(orient_reg[3])))
        else $error("orientation changed outside turn completion");

endmodule

`default_nettype wire

### test/quaternion_orientation_rotator_top_tb.sv
// Testbench for the quaternion rotator: random and directed beats checked against a predictor.
`timescale 1ns / 100ps

module quaternion_orientation_rotator_top_tb
    import qor_pkg::*;
;

    localparam longint CYCLE_LIMIT = 2000000;
    localparam int     PHASES      = 6;
    localparam int     PHASE_ITEMS = 183;

    // Predicts orientation updates and rotated vectors, and checks output beats
    class orient_scoreboard;
        longint    cos_q, sin_q, thresh;
        longint    q_s, q_x, q_y, q_z;
        out_item_t pending[$];
        int        errors;

        function new();
            cos_q  = 16135;
            sin_q  = 2845;
            thresh = 16384;
            q_s    = 16384;
            q_x    = 0;
            q_y    = 0;
            q_z    = 0;
            errors = 0;
        endfunction

        // Divide rounding to nearest, ties away from zero; den is positive
        function longint round_div(longint num, longint den);
            longint mag;
            mag = (num < 0) ? -num : num;
            mag = (mag + den / 2) / den;
            return (num < 0) ? -mag : mag;
        endfunction

        function longint clamp(longint v, int w);
            longint hi;
            longint lo;
            hi = (64'sd1 <<< (w - 1)) - 1;
            lo = -hi - 1;
            return (v > hi) ? hi : ((v < lo) ? lo : v);
        endfunction

        function longint int_sqrt(longint v);
            longint unsigned rem;
            longint unsigned root;
            longint unsigned b;
            rem  = v;
            root = 0;
            b    = 64'd1 << 62;
            while (b > rem)
                b = b >> 2;
            while (b != 0)
            begin
                if (rem >= root + b)
                begin
                    rem  = rem - (root + b);
                    root = (root >> 1) + b;
                end
                else
                    root = root >> 1;
                b = b >> 2;
            end
            return root;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_STEP_COS)
                cos_q = longint'($signed(data));
            else if (idx == REG_STEP_SIN)
                sin_q = longint'($signed(data));
            else if (idx == REG_THRESH)
                thresh = longint'(data[THR_W-1:0]);
        endfunction

        // Work out the result of an accepted input beat and queue it
        function void note_input(in_item_t it);
            longint    vx, vy, vz, sn, ax, ay, az, ns, nx, ny, nz, len2, len;
            longint    ts, tx, ty, tz;
            out_item_t res;
            vx = longint'(it.vec_x);
            vy = longint'(it.vec_y);
            vz = longint'(it.vec_z);
            if (it.kind == KIND_TURN)
            begin
                sn = it.turn_sign ? -sin_q : sin_q;
                ax = round_div(vx * sn, 65536);
                ay = round_div(vy * sn, 65536);
                az = round_div(vz * sn, 65536);
                ns = round_div(cos_q * q_s - (ax * q_x + ay * q_y + az * q_z), 16384);
                nx = round_div(ax * q_s + q_x * cos_q + (q_y * az - q_z * ay), 16384);
                ny = round_div(ay * q_s + q_y * cos_q + (q_z * ax - q_x * az), 16384);
                nz = round_div(az * q_s + q_z * cos_q + (q_x * ay - q_y * ax), 16384);
                len2 = ns * ns + nx * nx + ny * ny + nz * nz;
                if (len2 != 0 && len2 < thresh * thresh)
                begin
                    len = int_sqrt(len2);
                    if (len > 0)
                    begin
                        ns = round_div(ns * 16384, len);
                        nx = round_div(nx * 16384, len);
                        ny = round_div(ny * 16384, len);
                        nz = round_div(nz * 16384, len);
                    end
                end
                q_s = clamp(ns, 16);
                q_x = clamp(nx, 16);
                q_y = clamp(ny, 16);
                q_z = clamp(nz, 16);
                res.out_s = QW'(q_s);
                res.out_x = VW'(q_x);
                res.out_y = VW'(q_y);
                res.out_z = VW'(q_z);
            end
            else
            begin
                res = '0;
                len2 = q_s * q_s + q_x * q_x + q_y * q_y + q_z * q_z;
                if (len2 != 0)
                begin
                    ts = -(vx * q_x + vy * q_y + vz * q_z);
                    tx = vx * q_s + (q_y * vz - q_z * vy);
                    ty = vy * q_s + (q_z * vx - q_x * vz);
                    tz = vz * q_s + (q_x * vy - q_y * vx);
                    nx = tx * q_s - q_x * ts - (ty * q_z - tz * q_y);
                    ny = ty * q_s - q_y * ts - (tz * q_x - tx * q_z);
                    nz = tz * q_s - q_z * ts - (tx * q_y - ty * q_x);
                    res.out_x = VW'(clamp(round_div(nx, len2), 24));
                    res.out_y = VW'(clamp(round_div(ny, len2), 24));
                    res.out_z = VW'(clamp(round_div(nz, len2), 24));
                end
            end
            pending.push_back(res);
        endfunction

        // Compare an output beat with the oldest prediction
        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (pending.size() == 0)
            begin
                $error("output beat with nothing predicted: %h", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.out_s !== exp_r.out_s)
            begin
                $error("out_s expected %0d got %0d", exp_r.out_s, got.out_s);
                errors++;
            end
            if (got.out_x !== exp_r.out_x)
            begin
                $error("out_x expected %0d got %0d", exp_r.out_x, got.out_x);
                errors++;
            end
            if (got.out_y !== exp_r.out_y)
            begin
                $error("out_y expected %0d got %0d", exp_r.out_y, got.out_y);
                errors++;
            end
            if (got.out_z !== exp_r.out_z)
            begin
                $error("out_z expected %0d got %0d", exp_r.out_z, got.out_z);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_item_t          in_data;
    logic              out_valid;
    logic              out_ready;
    out_item_t         out_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_index;
    logic [CFG_W-1:0]  wr_data;

    orient_scoreboard  sb;
    int                send_idle;
    int                recv_idle;
    longint            cycles = 0;

    quaternion_orientation_rotator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quaternion_orientation_rotator_top_tb NOT OK");
            $finish;
        end
    end

    // Drain output beats with random stalls; sample at the falling edge
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(out_data);
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    // Hold a beat until accepted, after an optional random gap
    task automatic send_beat(in_item_t it);
        int gap;
        gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(negedge clk);
        while (!in_ready);
        sb.note_input(it);
        @(posedge clk);
    endtask

    task automatic send_vec(logic kind, logic sgn, int x, int y, int z);
        in_item_t it;
        it.kind      = kind;
        it.turn_sign = sgn;
        it.vec_x     = VW'(x);
        it.vec_y     = VW'(y);
        it.vec_z     = VW'(z);
        send_beat(it);
    endtask

    // Drop valid and wait until every predicted beat has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_beat();
        in_item_t it;
        int       pick;
        it.kind      = 1'($urandom_range(1));
        it.turn_sign = 1'($urandom_range(1));
        pick = $urandom_range(99);
        do
        begin
            if (pick < 40)
            begin
                it.vec_x = '0;
                it.vec_y = '0;
                it.vec_z = '0;
                case ($urandom_range(2))
                    0: it.vec_x = VW'($urandom_range(1) ? 65536 : -65536);
                    1: it.vec_y = VW'($urandom_range(1) ? 65536 : -65536);
                    default: it.vec_z = VW'($urandom_range(1) ? 65536 : -65536);
                endcase
            end
            else if (pick < 88)
            begin
                it.vec_x = VW'($signed($urandom_range(131072)) - 65536);
                it.vec_y = VW'($signed($urandom_range(131072)) - 65536);
                it.vec_z = VW'($signed($urandom_range(131072)) - 65536);
            end
            else
            begin
                it.vec_x = VW'($urandom);
                it.vec_y = VW'($urandom);
                it.vec_z = VW'($urandom);
            end
        end
        while (it.vec_x > -4096 && it.vec_x < 4096 && it.vec_y > -4096 && it.vec_y < 4096
               && it.vec_z > -4096 && it.vec_z < 4096);
        send_beat(it);
    endtask

    initial
    begin
        int cfg_cos[PHASES];
        int cfg_sin[PHASES];
        int cfg_thr[PHASES];
        cfg_cos = '{16135, 16384, 0, -16384, 11585, 16300};
        cfg_sin = '{2845, 0, 16384, -16384, 11585, -1800};
        cfg_thr = '{16384, 16384, 32767, 16000, 0, 16384};
        sb        = new();
        send_idle = 31;
        recv_idle = 61;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        wr_en     <= 1'b0;
        wr_index  <= '0;
        wr_data   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: rotate from identity, field extremes, each axis and sign
        send_vec(KIND_ROTATE, 1'b0, 8388607, -8388608, 65536);
        send_vec(KIND_TURN, 1'b0, 65536, 0, 0);
        send_vec(KIND_TURN, 1'b1, 0, 65536, 0);
        send_vec(KIND_TURN, 1'b0, 0, 0, -65536);
        send_vec(KIND_ROTATE, 1'b1, 65536, 131072, -196608);
        send_vec(KIND_TURN, 1'b0, 0, 0, 0);
        send_vec(KIND_ROTATE, 1'b0, -8388608, 8388607, -8388608);
        send_vec(KIND_TURN, 1'b0, 8388607, 8388607, 8388607);
        send_vec(KIND_TURN, 1'b1, -8388608, -8388608, -8388608);
        send_vec(KIND_ROTATE, 1'b0, 8388607, 8388607, 8388607);
        drain();
        // Pull a saturated orientation back to unit length
        write_reg(REG_STEP_COS, 16'd1);
        write_reg(REG_STEP_SIN, 16'd0);
        send_vec(KIND_TURN, 1'b0, 0, 0, 0);
        send_vec(KIND_ROTATE, 1'b1, 65536, 0, 0);
        drain();
        // Register index past the list is ignored
        write_reg(2'd3, 16'hFFFF);

        // Random phases, each with its own register setting; the idling mode changes every two phases
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_reg(REG_STEP_COS, CFG_W'(cfg_cos[p]));
            write_reg(REG_STEP_SIN, CFG_W'(cfg_sin[p]));
            write_reg(REG_THRESH, CFG_W'(cfg_thr[p]));
            if (p < 2)
            begin
                send_idle = 31;
                recv_idle = 61;
            end
            else if (p < 4)
            begin
                send_idle = 61;
                recv_idle = 31;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_beat();
        end

        // Zero product, then rotate with a zero orientation
        drain();
        write_reg(REG_STEP_COS, 16'd0);
        write_reg(REG_STEP_SIN, 16'd0);
        send_vec(KIND_TURN, 1'b0, 65536, 0, 0);
        send_vec(KIND_ROTATE, 1'b0, 65536, -65536, 8388607);
        drain();
        repeat (400) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("quaternion_orientation_rotator_top_tb OK");
        else
            $display("quaternion_orientation_rotator_top_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
design/qor_pkg.sv
design/qor_mac.sv
design/qor_div.sv
design/qor_root.sv
design/quaternion_orientation_rotator_top.sv
test/quaternion_orientation_rotator_top_tb.sv
